[sv/iopr_pkg.sv]
// Shared types, codes and constants of the in-order packet reorder window.
package iopr_pkg;

  localparam int SEQ_WIDTH  = 16;
  localparam int MAX_WINDOW = 64;
  localparam int WIN_BITS   = 7;
  localparam int SB_BITS    = 5;
  localparam int IDX_BITS   = $clog2(MAX_WINDOW);

  // Configuration register indexes.
  localparam logic [1:0] REG_SEQ_BITS = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_INIT_EXP = 2'd2;

  // Result outcome codes.
  typedef enum logic [2:0] {
    OUT_DELIVERED = 3'd0,
    OUT_HELD      = 3'd1,
    OUT_OUTSIDE   = 3'd2,
    OUT_DUPLICATE = 3'd3,
    OUT_INVALID   = 3'd4
  } outcome_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CLASS,
    ST_RUN,
    ST_RESTART
  } state_t;

  // Effective configuration seen by the sequencer.
  typedef struct packed {
    logic [SEQ_WIDTH-1:0] mask;
    logic [WIN_BITS-1:0]  win;
    logic [SEQ_WIDTH-1:0] init_exp;
    logic                 restart;
  } cfg_t;

endpackage

[sv/in_order_packet_reorder_window.sv]
// Top level: reorder window sequencer with its held-id bitmap and result register.
// A held or dropped id passes through the accept, distance and classify states;
// its result word is loaded once classify finds the output register free.
// A delivering id then starts a run that delivers 1..64 ids, as the run walks
// the held bitmap one bit a cycle, while the output is free, through the shared adder.
// Synchronous reset loads expected id 0 and clears the bitmap; no clearing pass.
module in_order_packet_reorder_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [15:0] packet_id
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // [15:0] seq_id, [31:16] next_expected
  output logic [2:0]                     m_tuser,   // [2:0] outcome
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [iopr_pkg::SEQ_WIDTH-1:0] cfg_data
);
  import iopr_pkg::*;

  cfg_t                 cfg;
  state_t               state, state_next;
  logic [SEQ_WIDTH-1:0] expected_id, expected_id_next;
  logic [MAX_WINDOW-1:0] held_map, held_map_next;
  logic [SEQ_WIDTH-1:0] id_reg, id_reg_next;
  logic [SEQ_WIDTH-1:0] diff, diff_next;
  logic                 invalid, invalid_next;
  logic                 out_valid_next;
  outcome_t             out_outcome, out_outcome_next;
  logic [SEQ_WIDTH-1:0] out_id, out_id_next;
  logic [SEQ_WIDTH-1:0] out_nxt, out_nxt_next;
  logic                 out_last, out_last_next;
  logic                 out_free;
  logic [SEQ_WIDTH-1:0] unit_a, unit_b, unit_sum;
  logic                 unit_sub;
  logic [IDX_BITS-1:0]  hold_idx;

  iopr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Shared add/subtract unit, result reduced to the sequence space.
  assign unit_sum = (unit_sub ? (unit_a - unit_b) : (unit_a + unit_b)) & cfg.mask;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign hold_idx = diff[IDX_BITS-1:0];

  // Sequencer: next state, datapath updates and result register loads.
  always_comb begin
    state_next       = state;
    expected_id_next = expected_id;
    held_map_next    = held_map;
    id_reg_next      = id_reg;
    diff_next        = diff;
    invalid_next     = invalid;
    out_valid_next   = m_tvalid && !m_tready;
    out_outcome_next = out_outcome;
    out_id_next      = out_id;
    out_nxt_next     = out_nxt;
    out_last_next    = out_last;
    unit_a           = expected_id;
    unit_b           = SEQ_WIDTH'(1);
    unit_sub         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          id_reg_next = s_tdata;
          state_next  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        // Modular distance from the expected id, plus the range check.
        unit_a       = id_reg;
        unit_b       = expected_id;
        unit_sub     = 1'b1;
        diff_next    = unit_sum;
        invalid_next = (id_reg & ~cfg.mask) != '0;
        state_next   = ST_CLASS;
      end
      ST_CLASS: begin
        if (invalid || diff >= SEQ_WIDTH'(cfg.win) || diff != '0) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            out_id_next    = id_reg;
            out_nxt_next   = expected_id;
            out_last_next  = 1'b1;
            if (invalid) begin
              out_outcome_next = OUT_INVALID;
            end else if (diff >= SEQ_WIDTH'(cfg.win)) begin
              out_outcome_next = OUT_OUTSIDE;
            end else if (held_map[hold_idx]) begin
              out_outcome_next = OUT_DUPLICATE;
            end else begin
              out_outcome_next        = OUT_HELD;
              held_map_next[hold_idx] = 1'b1;
            end
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // Deliver one id a cycle, while the output is free, as long as the following id is held.
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_outcome_next = OUT_DELIVERED;
          out_id_next      = expected_id;
          out_nxt_next     = unit_sum;
          out_last_next    = !held_map[1];
          expected_id_next = unit_sum;
          held_map_next    = held_map >> 1;
          if (!held_map[1]) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_RESTART: begin
        expected_id_next = cfg.init_exp & cfg.mask;
        held_map_next    = '0;
        state_next       = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // A write to a known register restarts the window with the new settings.
    if (cfg.restart) begin
      state_next = ST_RESTART;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      expected_id <= '0;
      held_map    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      expected_id <= expected_id_next;
      held_map    <= held_map_next;
      m_tvalid    <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    id_reg      <= id_reg_next;
    diff        <= diff_next;
    invalid     <= invalid_next;
    out_outcome <= out_outcome_next;
    out_id      <= out_id_next;
    out_nxt     <= out_nxt_next;
    out_last    <= out_last_next;
  end

  assign m_tdata = {out_nxt, out_id};
  assign m_tuser = out_outcome;
  assign m_tlast = out_last;

endmodule

[sv/iopr_cfg.sv]
// Configuration registers and the derived sequence mask and window width.
module iopr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [iopr_pkg::SEQ_WIDTH-1:0] cfg_data,
  output iopr_pkg::cfg_t                cfg
);
  import iopr_pkg::*;

  logic [SB_BITS-1:0]   seq_bits;
  logic [WIN_BITS-1:0]  window_size;
  logic [SEQ_WIDTH-1:0] initial_expected;
  logic [SB_BITS-1:0]   sb_eff;
  logic [SEQ_WIDTH-1:0] mask;
  logic [WIN_BITS-1:0]  win_clamp;
  logic [WIN_BITS-1:0]  win_lim;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits         <= SB_BITS'(8);
      window_size      <= WIN_BITS'(8);
      initial_expected <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEQ_BITS: seq_bits         <= cfg_data[SB_BITS-1:0];
        REG_WINDOW:   window_size      <= cfg_data[WIN_BITS-1:0];
        REG_INIT_EXP: initial_expected <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the sequence width and build the id mask.
  always_comb begin
    if (seq_bits == '0) begin
      sb_eff = SB_BITS'(1);
    end else if (seq_bits > SB_BITS'(SEQ_WIDTH)) begin
      sb_eff = SB_BITS'(SEQ_WIDTH);
    end else begin
      sb_eff = seq_bits;
    end
    mask = {SEQ_WIDTH{1'b1}} >> (SB_BITS'(SEQ_WIDTH) - sb_eff);
  end

  // Clamp the window to one..MAX_WINDOW and below the space size.
  always_comb begin
    if (window_size == '0) begin
      win_clamp = WIN_BITS'(1);
    end else if (window_size > WIN_BITS'(MAX_WINDOW)) begin
      win_clamp = WIN_BITS'(MAX_WINDOW);
    end else begin
      win_clamp = window_size;
    end
    win_lim = (mask < SEQ_WIDTH'(MAX_WINDOW)) ? mask[WIN_BITS-1:0] : WIN_BITS'(MAX_WINDOW);
  end

  assign cfg.mask     = mask;
  assign cfg.win      = (win_clamp > win_lim) ? win_lim : win_clamp;
  assign cfg.init_exp = initial_expected;
  assign cfg.restart  = cfg_we &&
                        (cfg_index inside {REG_SEQ_BITS, REG_WINDOW, REG_INIT_EXP});

endmodule
